FILE: rtl/tapc_pkg.sv
// Shared types and constants for the tracker announce peer collector.
package tapc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] peer_addr;
        logic [15:0] peer_port_num;
        logic [5:0]  peer_slot;
        logic [2:0]  status;
        logic [31:0] interval_secs;
        logic [31:0] leecher_count;
        logic [31:0] seeder_count;
        logic [6:0]  peers_stored;
        logic        trailing_bytes;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
    } peer_t;

    typedef struct packed {
        logic [7:0] rec_byte;
        logic [2:0] rec_idx;
        logic       cmp_en;
        logic       shift_en;
    } cell_ctl_t;

    localparam int unsigned HDR_LEN       = 20;
    localparam int unsigned HDR_WORDS     = 5;
    localparam logic [2:0]  REC_LAST_IDX  = 3'd5;
    localparam logic [7:0]  LOOPBACK_OCTET = 8'd127;

    localparam logic [31:0] ACTION_ANNOUNCE = 32'd1;
    localparam logic [31:0] ACTION_ERROR    = 32'd3;

    localparam logic KIND_PEER    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_TRACKER_ERR = 3'd2;
    localparam logic [2:0] ST_BAD_ACTION = 3'd3;
    localparam logic [2:0] ST_TXID_BAD   = 3'd4;

    localparam logic CFG_EXPECTED_TXID = 1'b0;
    localparam logic CFG_PEER_LIMIT    = 1'b1;

    localparam logic [6:0] PEER_LIMIT_RESET = 7'd64;

endpackage

FILE: rtl/tracker_announce_peer_collector.sv
// Announce parser: one byte per cycle if not stalled; first result is valid the cycle after accept.
// A byte that appends a peer and ends the datagram gives two results: the peer, then the summary.
// The duplicate search runs byte by byte in the cell chain as each record arrives, so it never stalls.
// Throughput is one item per cycle while the result side keeps up and no second result is pending.
// Synchronous active-low reset clears packet state, fill count, txid and valid flags; peer limit = 64.
// Table cells are not cleared; only entries below the fill count are ever compared.
module tracker_announce_peer_collector #(
    parameter int unsigned TABLE_DEPTH  = 64,
    parameter int unsigned MAX_DATAGRAM = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tapc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tapc_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import tapc_pkg::*;

    localparam int unsigned POS_W  = $clog2(MAX_DATAGRAM + 1);
    localparam int unsigned FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CMP_W  = (FILL_W > 7) ? FILL_W : 7;

    logic [31:0]       txid_reg;
    logic [6:0]        limit_reg;
    logic [POS_W-1:0]  pos_reg, pos_next, pos_upd;
    logic [31:0]       hdr_reg [HDR_WORDS];
    logic [31:0]       hdr_next [HDR_WORDS];
    logic [31:0]       hdr_upd [HDR_WORDS];
    logic [39:0]       buf_reg, buf_next;
    logic [2:0]        idx_reg, idx_next, idx_upd;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic              take;
    logic              in_range;
    logic              in_hdr;
    logic              in_rec;
    logic              rec_done;
    logic [2:0]        hdr_w;
    logic              hdr_ok;
    logic              full;
    logic              dup;
    logic              append;
    logic [CMP_W-1:0]  fill_ext;
    logic [CMP_W-1:0]  fill_new_ext;
    logic [2:0]        status;
    peer_t             new_peer;
    cell_ctl_t         ctl;
    logic              buf_ready;
    logic              has0, has1;
    out_item_t         res0, res1;
    out_item_t         peer_res, sum_res;

    peer_t             chain_peer [TABLE_DEPTH];
    logic [TABLE_DEPTH:0] hit_chain;
    logic [TABLE_DEPTH-1:0] live;

    assign s_ready  = buf_ready && aresetn;
    assign take     = s_valid && s_ready;
    assign in_range = pos_reg < POS_W'(MAX_DATAGRAM);
    assign in_hdr   = pos_reg < POS_W'(HDR_LEN);
    assign in_rec   = in_range && !in_hdr;
    assign rec_done = in_rec && (idx_reg == REC_LAST_IDX);
    assign hdr_w    = pos_reg[4:2];

    assign new_peer.addr = buf_reg[39:8];
    assign new_peer.port = {buf_reg[7:0], s_data.rx_byte};

    assign hdr_ok   = (hdr_reg[0] == ACTION_ANNOUNCE) && (hdr_reg[1] == txid_reg);
    assign fill_ext = CMP_W'(fill_reg);
    assign full     = (fill_ext >= CMP_W'(limit_reg)) || (fill_reg == FILL_W'(TABLE_DEPTH));
    assign dup      = hit_chain[TABLE_DEPTH];
    assign append   = take && rec_done && hdr_ok && !full && !dup &&
                      (new_peer.addr[31:24] != LOOPBACK_OCTET);

    assign ctl.rec_byte = s_data.rx_byte;
    assign ctl.rec_idx  = idx_reg;
    assign ctl.cmp_en   = take && in_rec;
    assign ctl.shift_en = append;

    assign hit_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            peer_t cell_in;
            assign live[gi] = fill_reg > FILL_W'(gi);
            if (gi == 0) begin : g_head
                assign cell_in = new_peer;
            end else begin : g_body
                assign cell_in = chain_peer[gi-1];
            end
            tapc_cell u_cell (
                .aclk     (aclk),
                .ctl      (ctl),
                .live     (live[gi]),
                .peer_in  (cell_in),
                .peer_out (chain_peer[gi]),
                .hit_in   (hit_chain[gi]),
                .hit_out  (hit_chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < HDR_WORDS; i++) begin
            hdr_upd[i] = hdr_reg[i];
        end
        pos_upd = pos_reg;
        idx_upd = idx_reg;
        buf_next = buf_reg;
        if (take && in_range) begin
            pos_upd = pos_reg + POS_W'(1);
            if (in_hdr) begin
                hdr_upd[hdr_w] = {hdr_reg[hdr_w][23:0], s_data.rx_byte};
            end else if (idx_reg != REC_LAST_IDX) begin
                buf_next = {buf_reg[31:0], s_data.rx_byte};
                idx_upd  = idx_reg + 3'd1;
            end else begin
                buf_next = 40'd0;
                idx_upd  = 3'd0;
            end
        end
        fill_next = fill_reg + FILL_W'(append);
        pos_next  = pos_upd;
        idx_next  = idx_upd;
        for (int i = 0; i < HDR_WORDS; i++) begin
            hdr_next[i] = hdr_upd[i];
        end
        if (take && s_data.end_of_packet) begin
            pos_next = '0;
            idx_next = 3'd0;
            buf_next = 40'd0;
            for (int i = 0; i < HDR_WORDS; i++) begin
                hdr_next[i] = 32'd0;
            end
        end
    end

    always_comb begin
        if (pos_upd < POS_W'(HDR_LEN)) begin
            status = ST_SHORT;
        end else if (hdr_upd[0] == ACTION_ERROR) begin
            status = ST_TRACKER_ERR;
        end else if (hdr_upd[0] != ACTION_ANNOUNCE) begin
            status = ST_BAD_ACTION;
        end else if (hdr_upd[1] != txid_reg) begin
            status = ST_TXID_BAD;
        end else begin
            status = ST_OK;
        end
    end

    assign fill_new_ext = CMP_W'(fill_next);

    always_comb begin
        peer_res                = '0;
        peer_res.kind           = KIND_PEER;
        peer_res.peer_addr      = new_peer.addr;
        peer_res.peer_port_num  = new_peer.port;
        peer_res.peer_slot      = fill_ext[5:0];
        peer_res.peers_stored   = fill_new_ext[6:0];
        peer_res.last           = !s_data.end_of_packet;

        sum_res                 = '0;
        sum_res.kind            = KIND_SUMMARY;
        sum_res.status          = status;
        sum_res.peers_stored    = fill_new_ext[6:0];
        sum_res.last            = 1'b1;
        if (status == ST_OK) begin
            sum_res.interval_secs  = hdr_upd[2];
            sum_res.leecher_count  = hdr_upd[3];
            sum_res.seeder_count   = hdr_upd[4];
            sum_res.trailing_bytes = (idx_upd != 3'd0);
        end

        has0 = append || s_data.end_of_packet;
        has1 = append && s_data.end_of_packet;
        res0 = append ? peer_res : sum_res;
        res1 = sum_res;
    end

    tapc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (take),
        .has0     (has0),
        .has1     (has1),
        .res0     (res0),
        .res1     (res1),
        .can_push (buf_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txid_reg  <= 32'd0;
            limit_reg <= PEER_LIMIT_RESET;
            pos_reg   <= '0;
            idx_reg   <= 3'd0;
            buf_reg   <= 40'd0;
            fill_reg  <= '0;
            for (int i = 0; i < HDR_WORDS; i++) begin
                hdr_reg[i] <= 32'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_EXPECTED_TXID: txid_reg  <= cfg_wdata;
                    CFG_PEER_LIMIT:    limit_reg <= cfg_wdata[6:0];
                    default:           txid_reg  <= txid_reg;
                endcase
            end
            pos_reg  <= pos_next;
            idx_reg  <= idx_next;
            buf_reg  <= buf_next;
            fill_reg <= fill_next;
            for (int i = 0; i < HDR_WORDS; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

endmodule

FILE: rtl/tapc_cell.sv
// One table cell: holds a stored peer, matches incoming record bytes, shifts on append.
module tapc_cell (
    input  logic              aclk,
    input  tapc_pkg::cell_ctl_t ctl,
    input  logic              live,
    input  tapc_pkg::peer_t   peer_in,
    output tapc_pkg::peer_t   peer_out,
    input  logic              hit_in,
    output logic              hit_out
);
    import tapc_pkg::*;

    peer_t      entry_reg;
    logic       match_reg;
    logic [7:0] sel_byte;
    logic       prefix;
    logic       hit_local;

    always_comb begin
        case (ctl.rec_idx)
            3'd0: sel_byte = entry_reg.addr[31:24];
            3'd1: sel_byte = entry_reg.addr[23:16];
            3'd2: sel_byte = entry_reg.addr[15:8];
            3'd3: sel_byte = entry_reg.addr[7:0];
            3'd4: sel_byte = entry_reg.port[15:8];
            3'd5: sel_byte = entry_reg.port[7:0];
            default: sel_byte = 8'h00;
        endcase
    end

    assign prefix    = (ctl.rec_idx == 3'd0) | match_reg;
    assign hit_local = live & prefix & (sel_byte == ctl.rec_byte);
    assign hit_out   = hit_in | hit_local;
    assign peer_out  = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctl.cmp_en) begin
            match_reg <= hit_local;
        end
        if (ctl.shift_en) begin
            entry_reg <= peer_in;
        end
    end

endmodule

FILE: rtl/tapc_out_buf.sv
// Two-entry result buffer that lets one input item yield up to two result items.
module tapc_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  logic                has0,
    input  logic                has1,
    input  tapc_pkg::out_item_t res0,
    input  tapc_pkg::out_item_t res1,
    output logic                can_push,
    output logic                m_valid,
    input  logic                m_ready,
    output tapc_pkg::out_item_t m_data
);
    import tapc_pkg::*;

    logic      out_v_reg, out_v_next;
    logic      pend_v_reg, pend_v_next;
    out_item_t out_reg, out_next;
    out_item_t pend_reg, pend_next;

    assign can_push = !pend_v_reg && (!out_v_reg || m_ready);
    assign m_valid  = out_v_reg;
    assign m_data   = out_reg;

    always_comb begin
        out_v_next  = out_v_reg;
        pend_v_next = pend_v_reg;
        out_next    = out_reg;
        pend_next   = pend_reg;
        if (push) begin
            out_v_next  = has0;
            out_next    = res0;
            pend_v_next = has1;
            pend_next   = res1;
        end else if (out_v_reg && m_ready) begin
            if (pend_v_reg) begin
                out_next    = pend_reg;
                pend_v_next = 1'b0;
            end else begin
                out_v_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            pend_v_reg <= pend_v_next;
        end
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule
